// File: rtl/core/assert_macros.svh
// Assertion macros used by the checker file of this block.
// Depends on nothing; included by files that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
	else $error("assertion failed: same-cycle implication");

// Next-cycle implication, checked at every rising edge outside reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
	else $error("assertion failed: next-cycle implication");

`endif

// File: rtl/core/cbt_pkg.sv
// Constants, register codes and helper functions of the cosine blend trajectory.
// Depends on nothing; used by the top level.
`timescale 1ns / 1ps

package cbt_pkg;

	// Default fixed-point formats.
	localparam int FRAC_BITS_DEF  = 16;
	localparam int ANGLE_BITS_DEF = 18;

	// Rotation unit and scaling constants.
	localparam int                 CORDIC_STEPS = 30;
	localparam logic signed [32:0] CORDIC_GAIN  = 33'sd652032874;
	localparam logic [31:0]        PI_Q30       = 32'd3373259426;
	localparam logic [29:0]        PI_Q28       = 30'd843314857;
	localparam logic [22:0]        PI_Q21       = 23'd6588397;

	// Configuration register indexes.
	typedef enum logic [1:0] {
		REG_START    = 2'd0,
		REG_END      = 2'd1,
		REG_DURATION = 2'd2
	} cfg_reg_t;

	// Arctangent of 2^-i in Q30.
	function automatic logic signed [32:0] atan_q30(input logic [4:0] i);
		logic signed [32:0] v;
		case (i)
			5'd0: v = 33'sh03243F6A8;
			5'd1: v = 33'sh01DAC6705;
			5'd2: v = 33'sh00FADBAFC;
			5'd3: v = 33'sh007F56EA6;
			5'd4: v = 33'sh003FEAB76;
			5'd5: v = 33'sh001FFD55B;
			5'd6: v = 33'sh000FFFAAA;
			5'd7: v = 33'sh0007FFF55;
			5'd8: v = 33'sh0003FFFEA;
			5'd9: v = 33'sh0001FFFFD;
			5'd10: v = 33'sh0000FFFFF;
			5'd11: v = 33'sh00007FFFF;
			5'd12: v = 33'sh00003FFFF;
			5'd13: v = 33'sh00001FFFF;
			5'd14: v = 33'sh00000FFFF;
			5'd15: v = 33'sh000007FFF;
			5'd16: v = 33'sh000003FFF;
			5'd17: v = 33'sh000001FFF;
			5'd18: v = 33'sh000000FFF;
			5'd19: v = 33'sh0000007FF;
			5'd20: v = 33'sh0000003FF;
			5'd21: v = 33'sh0000001FF;
			5'd22: v = 33'sh0000000FF;
			5'd23: v = 33'sh00000007F;
			5'd24: v = 33'sh00000003F;
			5'd25: v = 33'sh00000001F;
			5'd26: v = 33'sh00000000F;
			5'd27: v = 33'sh000000008;
			5'd28: v = 33'sh000000004;
			5'd29: v = 33'sh000000002;
			default: v = 33'sh000000000;
		endcase
		return v;
	endfunction

	// Saturate a sign and magnitude pair to a signed 32-bit result.
	function automatic logic [31:0] sat_out(input logic neg, input logic [40:0] mag);
		logic [40:0] m;
		if (neg) begin
			m = (mag > 41'h080000000) ? 41'h080000000 : mag;
			return ~m[31:0] + 32'd1;
		end
		return (mag > 41'h07FFFFFFF) ? 32'h7FFFFFFF : mag[31:0];
	endfunction

endpackage

// File: rtl/core/cbt_div.sv
// Pipelined restoring divider, one quotient bit per stage, with an overflow flag.
// Depends on nothing; instantiated by the cosine blend trajectory top level.
`timescale 1ns / 1ps

module cbt_div #(
	parameter int NW = 64,
	parameter int DW = 32,
	parameter int QB = 32,
	parameter int SW = 1
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          in_valid,
	input  logic [NW-1:0] num,
	input  logic [DW-1:0] den,
	input  logic [SW-1:0] side,
	output logic          out_valid,
	output logic [QB-1:0] quo,
	output logic          ovf,
	output logic [SW-1:0] out_side
);

	localparam int HW = NW - QB;
	localparam int CW = (HW > DW) ? HW : DW;

	// The denominator comes from a configuration register that the user must hold steady while
	// requests are in flight (the block does not enforce this), so it is not carried down the stages.
	logic [CW-1:0] hi_ext;
	logic [CW-1:0] den_ext;
	assign hi_ext  = CW'(num[NW-1:QB]);
	assign den_ext = CW'(den);

	logic          vld_s  [0:QB];
	logic [DW-1:0] rem_s  [0:QB-1];
	logic [QB-1:0] qr_s   [0:QB];
	logic          ovf_s  [0:QB];
	logic [SW-1:0] side_s [0:QB];

	logic [DW:0]   trial  [0:QB-1];
	logic          ge     [0:QB-1];
	logic [DW-1:0] nrem   [0:QB-1];

	// One trial subtraction per stage; the numerator's low bits shift out of
	// the same register that collects the quotient bits.
	always_comb begin
		for (int k = 0; k < QB; k++) begin
			trial[k] = {rem_s[k], qr_s[k][QB-1]};
			ge[k]    = trial[k] >= {1'b0, den};
			nrem[k]  = ge[k] ? DW'(trial[k] - {1'b0, den}) : trial[k][DW-1:0];
		end
	end

	// Valid bits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k <= QB; k++) begin
				vld_s[k] <= 1'b0;
			end
		end else if (en) begin
			vld_s[0] <= in_valid;
			for (int k = 0; k < QB; k++) begin
				vld_s[k+1] <= vld_s[k];
			end
		end
	end

	// Stage payload.
	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0]  <= hi_ext[DW-1:0];
			qr_s[0]   <= num[QB-1:0];
			ovf_s[0]  <= hi_ext >= den_ext;
			side_s[0] <= side;
			for (int k = 0; k < QB; k++) begin
				if (k < QB - 1) begin
					rem_s[k+1] <= nrem[k];
				end
				qr_s[k+1]   <= {qr_s[k][QB-2:0], ge[k]};
				ovf_s[k+1]  <= ovf_s[k];
				side_s[k+1] <= side_s[k];
			end
		end
	end

	assign out_valid = vld_s[QB];
	assign quo       = qr_s[QB];
	assign ovf       = ovf_s[QB];
	assign out_side  = side_s[QB];

endmodule

// File: rtl/core/cosine_blend_trajectory.sv
// Channel  Direction  Payload (lowest bits first)
// s_*      in         sample_time[31:0]
// m_*      out        position[31:0], velocity[63:32], acceleration[95:64]
// cfg_*    in         start_value, end_value, duration by register index
//
// One request enters per cycle unless a waiting result stalls the pipeline.
// Requests pass the phase divider, the CORDIC stages and three more dividers.
// Reset clears the valid bits and loads the configuration registers with their reset values.
// A stall on m_tready freezes the whole pipeline; nothing is dropped or repeated.
// Top level of the cosine blend trajectory; depends on cbt_pkg and cbt_div.
`timescale 1ns / 1ps

module cosine_blend_trajectory
	import cbt_pkg::*;
#(
	parameter int FRAC_BITS  = FRAC_BITS_DEF,
	parameter int ANGLE_BITS = ANGLE_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // sample_time[31:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [95:0] m_tdata,   // position[31:0], velocity[63:32], acceleration[95:64]
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_wdata
);

	localparam int AW    = ANGLE_BITS + 1;
	localparam int SHP1  = (FRAC_BITS > 29) ? FRAC_BITS - 29 : 0;
	localparam int SHN1  = (FRAC_BITS < 29) ? 29 - FRAC_BITS : 0;
	localparam int SHP2  = (FRAC_BITS > 21) ? FRAC_BITS - 21 : 0;
	localparam int SHN2  = (FRAC_BITS < 21) ? 21 - FRAC_BITS : 0;
	localparam int DW1   = 32 + SHN1;
	localparam int NW1   = 64 + SHP1;
	localparam int DW2   = 32 + SHN2;
	localparam int NW2   = 65 + SHP2;
	localparam int QB1   = 40;
	localparam int QB2   = 32;
	localparam logic [AW-1:0] FULL = AW'(1) << ANGLE_BITS;
	localparam logic [AW-1:0] HALF = AW'(1) << (ANGLE_BITS - 1);

	// Configuration registers.
	logic [31:0] start_q;
	logic [31:0] end_q;
	logic [31:0] dur_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q <= 32'd0;
			end_q   <= 32'd0;
			dur_q   <= 32'd1 << FRAC_BITS;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_START:    start_q <= cfg_wdata;
				REG_END:      end_q   <= cfg_wdata;
				REG_DURATION: dur_q   <= cfg_wdata;
				default:      ;
			endcase
		end
	end

	// A zero duration acts as the smallest one.
	logic [31:0] d_eff;
	logic [DW1-1:0] den1;
	logic [DW2-1:0] den2;
	assign d_eff = (dur_q == 32'd0) ? 32'd1 : dur_q;
	assign den1  = DW1'(d_eff) << SHN1;
	assign den2  = DW2'(d_eff) << SHN2;

	// The whole pipeline advances unless a finished result is waiting.
	logic en;
	logic out_vld_q;
	assign en       = !out_vld_q || m_tready;
	assign s_tready = en;

	// Phase: floor(t * 2^ANGLE_BITS / D).
	logic          ang_vld;
	logic [AW-1:0] ang_quo;
	logic          ang_ovf;
	logic          ang_past;

	cbt_div #(.NW(32 + ANGLE_BITS), .DW(32), .QB(AW), .SW(1)) u_ang_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (s_tvalid),
		.num       ({s_tdata, ANGLE_BITS'(0)}),
		.den       (d_eff),
		.side      (s_tdata > d_eff),
		.out_valid (ang_vld),
		.quo       (ang_quo),
		.ovf       (ang_ovf),
		.out_side  (ang_past)
	);

	// Fold the phase into the first quadrant and scale to radians in Q30.
	logic [AW-1:0]    af;
	logic             fneg;
	logic [AW+31:0]   zprod;
	logic             vld_s1;
	logic             neg_s1;
	logic             past_s1;
	logic signed [32:0] z_s1;

	always_comb begin
		fneg  = ang_quo > HALF;
		af    = fneg ? FULL - ang_quo : ang_quo;
		zprod = (AW+32)'(af) * (AW+32)'(PI_Q30);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= ang_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			neg_s1  <= fneg;
			past_s1 <= ang_past || ang_ovf;
			z_s1    <= signed'(zprod[ANGLE_BITS +: 33]);
		end
	end

	// CORDIC rotation, one step per stage.
	logic               cvld_s  [1:CORDIC_STEPS];
	logic               cneg_s  [1:CORDIC_STEPS];
	logic               cpast_s [1:CORDIC_STEPS];
	logic signed [32:0] cx_s    [1:CORDIC_STEPS];
	logic signed [32:0] cy_s    [1:CORDIC_STEPS];
	logic signed [32:0] cz_s    [1:CORDIC_STEPS];
	logic signed [32:0] xin     [0:CORDIC_STEPS-1];
	logic signed [32:0] yin     [0:CORDIC_STEPS-1];
	logic signed [32:0] zin     [0:CORDIC_STEPS-1];
	logic signed [32:0] nx      [0:CORDIC_STEPS-1];
	logic signed [32:0] ny      [0:CORDIC_STEPS-1];
	logic signed [32:0] nz      [0:CORDIC_STEPS-1];

	always_comb begin
		for (int i = 0; i < CORDIC_STEPS; i++) begin
			if (i == 0) begin
				xin[i] = CORDIC_GAIN;
				yin[i] = 33'sd0;
				zin[i] = z_s1;
			end else begin
				xin[i] = cx_s[i];
				yin[i] = cy_s[i];
				zin[i] = cz_s[i];
			end
			if (!zin[i][32]) begin
				nx[i] = xin[i] - (yin[i] >>> i);
				ny[i] = yin[i] + (xin[i] >>> i);
				nz[i] = zin[i] - atan_q30(5'(i));
			end else begin
				nx[i] = xin[i] + (yin[i] >>> i);
				ny[i] = yin[i] - (xin[i] >>> i);
				nz[i] = zin[i] + atan_q30(5'(i));
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 1; i <= CORDIC_STEPS; i++) begin
				cvld_s[i] <= 1'b0;
			end
		end else if (en) begin
			cvld_s[1] <= vld_s1;
			for (int i = 1; i < CORDIC_STEPS; i++) begin
				cvld_s[i+1] <= cvld_s[i];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cneg_s[1]  <= neg_s1;
			cpast_s[1] <= past_s1;
			for (int i = 1; i < CORDIC_STEPS; i++) begin
				cneg_s[i+1]  <= cneg_s[i];
				cpast_s[i+1] <= cpast_s[i];
			end
			for (int i = 0; i < CORDIC_STEPS; i++) begin
				cx_s[i+1] <= nx[i];
				cy_s[i+1] <= ny[i];
				cz_s[i+1] <= nz[i];
			end
		end
	end

	// Stage 2: sign of cosine, rounding to Q28, value difference.
	logic signed [32:0] xs;
	logic signed [32:0] c_full;
	logic signed [32:0] s_full;
	logic               vld_s2;
	logic               past_s2;
	logic signed [30:0] c28_s2;
	logic signed [30:0] s28_s2;
	logic signed [32:0] diff_s2;

	always_comb begin
		xs     = cneg_s[CORDIC_STEPS] ? -cx_s[CORDIC_STEPS] : cx_s[CORDIC_STEPS];
		c_full = (xs + 33'sd2) >>> 2;
		s_full = (cy_s[CORDIC_STEPS] + 33'sd2) >>> 2;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (en) begin
			vld_s2 <= cvld_s[CORDIC_STEPS];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			past_s2 <= cpast_s[CORDIC_STEPS];
			c28_s2  <= c_full[30:0];
			s28_s2  <= s_full[30:0];
			diff_s2 <= 33'(signed'(end_q)) - 33'(signed'(start_q));
		end
	end

	// Stage 3: the three products with the value difference.
	logic signed [31:0] k28;
	logic               vld_s3;
	logic               past_s3;
	logic signed [63:0] pm_s3;
	logic signed [63:0] am_s3;
	logic signed [63:0] cm_s3;

	assign k28 = 32'sd268435456 - 32'(c28_s2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else if (en) begin
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			past_s3 <= past_s2;
			pm_s3   <= 64'(diff_s2) * 64'(k28);
			am_s3   <= 64'(diff_s2) * 64'(s28_s2);
			cm_s3   <= 64'(diff_s2) * 64'(c28_s2);
		end
	end

	// Stage 4: position with saturation, rounded velocity and curvature terms.
	logic signed [63:0] pr;
	logic signed [35:0] psum;
	logic [31:0]        pos_c;
	logic signed [63:0] av;
	logic signed [63:0] cv;
	logic signed [63:0] av_abs;
	logic signed [63:0] cv_abs;
	logic               vld_s4;
	logic               past_s4;
	logic [31:0]        pos_s4;
	logic [32:0]        avm_s4;
	logic               avneg_s4;
	logic [32:0]        cvm_s4;
	logic               cvneg_s4;

	always_comb begin
		pr     = (pm_s3 + 64'sd268435456) >>> 29;
		psum   = 36'(signed'(start_q)) + 36'(pr);
		if (psum > 36'sd2147483647) begin
			pos_c = 32'h7FFFFFFF;
		end else if (psum < -36'sd2147483648) begin
			pos_c = 32'h80000000;
		end else begin
			pos_c = psum[31:0];
		end
		av     = (am_s3 + 64'sd134217728) >>> 28;
		cv     = (cm_s3 + 64'sd134217728) >>> 28;
		av_abs = av[63] ? -av : av;
		cv_abs = cv[63] ? -cv : cv;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
		end else if (en) begin
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			past_s4  <= past_s3;
			pos_s4   <= pos_c;
			avm_s4   <= av_abs[32:0];
			avneg_s4 <= av[63];
			cvm_s4   <= cv_abs[32:0];
			cvneg_s4 <= cv[63];
		end
	end

	// Stage 5: scale both terms by pi.
	logic        vld_s5;
	logic        past_s5;
	logic [31:0] pos_s5;
	logic        avneg_s5;
	logic        cvneg_s5;
	logic [62:0] mv_s5;
	logic [62:0] mc_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s5 <= 1'b0;
		end else if (en) begin
			vld_s5 <= vld_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			past_s5  <= past_s4;
			pos_s5   <= pos_s4;
			avneg_s5 <= avneg_s4;
			cvneg_s5 <= cvneg_s4;
			mv_s5    <= 63'(avm_s4) * 63'(PI_Q28);
			mc_s5    <= 63'(cvm_s4) * 63'(PI_Q28);
		end
	end

	// Stage 6: align numerators and add half a denominator for rounding.
	logic           vld_s6;
	logic           past_s6;
	logic [31:0]    pos_s6;
	logic           avneg_s6;
	logic           cvneg_s6;
	logic [NW1-1:0] nv_s6;
	logic [NW1-1:0] nc_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s6 <= 1'b0;
		end else if (en) begin
			vld_s6 <= vld_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			past_s6  <= past_s5;
			pos_s6   <= pos_s5;
			avneg_s6 <= avneg_s5;
			cvneg_s6 <= cvneg_s5;
			nv_s6    <= (NW1'(mv_s5) << SHP1) + NW1'(den1 >> 1);
			nc_s6    <= (NW1'(mc_s5) << SHP1) + NW1'(den1 >> 1);
		end
	end

	// Velocity and first acceleration division run side by side.
	logic           vdiv_vld;
	logic [QB1-1:0] vdiv_quo;
	logic           vdiv_ovf;
	logic           vdiv_neg;
	logic           cdiv_vld;
	logic [QB1-1:0] cdiv_quo;
	logic           cdiv_ovf;
	logic [33:0]    cdiv_side;

	cbt_div #(.NW(NW1), .DW(DW1), .QB(QB1), .SW(1)) u_vel_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (vld_s6),
		.num       (nv_s6),
		.den       (den1),
		.side      (avneg_s6),
		.out_valid (vdiv_vld),
		.quo       (vdiv_quo),
		.ovf       (vdiv_ovf),
		.out_side  (vdiv_neg)
	);

	cbt_div #(.NW(NW1), .DW(DW1), .QB(QB1), .SW(34)) u_acc1_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (vld_s6),
		.num       (nc_s6),
		.den       (den1),
		.side      ({past_s6, cvneg_s6, pos_s6}),
		.out_valid (cdiv_vld),
		.quo       (cdiv_quo),
		.ovf       (cdiv_ovf),
		.out_side  (cdiv_side)
	);

	// Stage 7: cap the intermediate at 2^40 and scale by pi again.
	logic [40:0] tmp_c;
	logic        vld_s7;
	logic [33:0] side_s7;
	logic        vneg_s7;
	logic [40:0] vmag_s7;
	logic [63:0] m2_s7;

	assign tmp_c = cdiv_ovf ? (41'd1 << 40) : {1'b0, cdiv_quo};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s7 <= 1'b0;
		end else if (en) begin
			vld_s7 <= vdiv_vld && cdiv_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s7 <= cdiv_side;
			vneg_s7 <= vdiv_neg;
			vmag_s7 <= vdiv_ovf ? {41{1'b1}} : {1'b0, vdiv_quo};
			m2_s7   <= 64'(tmp_c) * 64'(PI_Q21);
		end
	end

	// Stage 8: second numerator with rounding offset.
	logic           vld_s8;
	logic [33:0]    side_s8;
	logic           vneg_s8;
	logic [40:0]    vmag_s8;
	logic [NW2-1:0] n2_s8;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s8 <= 1'b0;
		end else if (en) begin
			vld_s8 <= vld_s7;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s8 <= side_s7;
			vneg_s8 <= vneg_s7;
			vmag_s8 <= vmag_s7;
			n2_s8   <= (NW2'(m2_s7) << SHP2) + NW2'(den2 >> 1);
		end
	end

	// Second acceleration division.
	logic           adiv_vld;
	logic [QB2-1:0] adiv_quo;
	logic           adiv_ovf;
	logic [75:0]    adiv_side;
	logic           a_past;
	logic           a_cneg;
	logic [31:0]    a_pos;
	logic           a_vneg;
	logic [40:0]    a_vmag;

	cbt_div #(.NW(NW2), .DW(DW2), .QB(QB2), .SW(76)) u_acc2_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (vld_s8),
		.num       (n2_s8),
		.den       (den2),
		.side      ({vneg_s8, vmag_s8, side_s8}),
		.out_valid (adiv_vld),
		.quo       (adiv_quo),
		.ovf       (adiv_ovf),
		.out_side  (adiv_side)
	);

	assign {a_vneg, a_vmag, a_past, a_cneg, a_pos} = adiv_side;

	// Output register: saturation and the past-the-end override.
	logic [31:0] pos_q;
	logic [31:0] vel_q;
	logic [31:0] acc_q;
	logic [40:0] amag;

	assign amag = adiv_ovf ? {41{1'b1}} : 41'(adiv_quo);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (en) begin
			out_vld_q <= adiv_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (a_past) begin
				pos_q <= end_q;
				vel_q <= 32'd0;
				acc_q <= 32'd0;
			end else begin
				pos_q <= a_pos;
				vel_q <= sat_out(a_vneg, a_vmag);
				acc_q <= sat_out(a_cneg, amag);
			end
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = {acc_q, vel_q, pos_q};

endmodule

// File: rtl/core/cbt_checker.sv
// Port-level checker for the cosine blend trajectory, bound to the top level.
// Depends on assert_macros.svh and the top level's port list.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module cbt_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [95:0] m_tdata
);

	// A result that is not taken stays on the bus unchanged.
	`ASSERT_NEXT(a_out_hold, clk, arst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

	// A waiting result stalls the input side.
	`ASSERT_IMPL(a_stall_in, clk, arst_n, m_tvalid && !m_tready, !s_tready)

	// A ready sink lets a request in.
	`ASSERT_IMPL(a_ready_pass, clk, arst_n, m_tready, s_tready)

	// With no result pending the input side is open.
	`ASSERT_IMPL(a_idle_ready, clk, arst_n, !m_tvalid, s_tready)

endmodule

bind cosine_blend_trajectory cbt_checker u_cbt_checker (.*);
